/* src/pmot_pkg.sv */
// pmot_pkg: shared types, constants and helpers of the particle motion step
// depends on nothing; used by every module of the block
package pmot_pkg;

    // fixed-point fraction bits of positions, velocities and times
    localparam int FRAC = 16;
    // attractor position is Q12.9, moved up to the working fraction
    localparam int ATT_SHIFT = FRAC - 9;
    // drag multiplier cap, 0.05 rounded to the working fraction
    localparam logic [11:0] MUL_CAP = 12'(((5 << FRAC) + 50) / 100);
    // speed squared cap, 100.0 in the doubled fraction
    localparam logic [63:0] VSQ_CAP = 64'(100) << (2 * FRAC);

    localparam int IN_W  = 328;
    localparam int OUT_W = 232;

    typedef enum logic [2:0] {
        REG_SIZE_X,
        REG_SIZE_Y,
        REG_MODE,
        REG_SHADES,
        REG_MAG,
        REG_APOS,
        REG_AXIS,
        REG_STRENGTH
    } cfg_index_t;

    typedef enum logic [1:0] {
        EDGE_WRAP,
        EDGE_HARD,
        EDGE_BOUNCE
    } edge_mode_t;

    typedef logic signed [31:0] s32_t;

    typedef struct packed {
        logic [11:0] size_x;
        logic [11:0] size_y;
        logic [4:0]  mode;
        logic [8:0]  num_shades;
        logic [62:0] mag;
        logic [62:0] apos;
        logic [47:0] axis;
        logic [31:0] strength;
    } cfg_t;

    // one particle travelling down the pipeline
    typedef struct packed {
        s32_t [2:0]  p;
        s32_t [2:0]  v;
        s32_t        qs;
        logic [31:0] drag;
        logic [30:0] dt;
        logic [7:0]  shade;
        logic [30:0] age;
        logic        dead;
    } item_t;

    function automatic s32_t sat32(input logic signed [63:0] x);
        if (x > 64'sh7FFFFFFF) begin
            return 32'sh7FFFFFFF;
        end else if (x < -64'sh80000000) begin
            return 32'sh80000000;
        end
        return x[31:0];
    endfunction

endpackage

/* src/particle_motion_step_top.sv */
// particle_motion_step_top: one Euler step per particle, streaming in and out
// depends on pmot_pkg, pmot_motion, pmot_drag and pmot_force
//
//  channel   direction  handshake          payload
//  s_        in         s_tvalid/s_tready  s_tdata particle word
//  m_        out        m_tvalid/m_tready  m_tdata updated particle, m_tuser dead
//  cfg_      in         cfg_wr_en          cfg_index, cfg_wdata
//
// one word per cycle sustained while m_tready is high; a word passes through the
// motion (2), drag (5) and force (7) stages, the last being the output register
// a stage advances when empty or when the stage after it advances, so bubbles
// close up and input is taken while a finished word waits at the output
// reset clears the valid bits and loads the register defaults
module particle_motion_step_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, drag, shade, age, lifetime,
    // time_step, zero fill
    input  logic [pmot_pkg::IN_W-1:0]   s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z,
    // new_shade, new_age, zero fill
    output logic [pmot_pkg::OUT_W-1:0]  m_tdata,
    // dead
    output logic [0:0]                  m_tuser,
    input  logic                        cfg_wr_en,
    input  logic [2:0]                  cfg_index,
    input  logic [62:0]                 cfg_wdata
);
    import pmot_pkg::*;

    cfg_t  cfg_reg;
    item_t mot_item, drg_item, frc_item;
    logic  mot_valid, mot_ready, drg_valid, drg_ready;

    // register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.size_x     <= 12'd128;
            cfg_reg.size_y     <= 12'd128;
            cfg_reg.mode       <= '0;
            cfg_reg.num_shades <= 9'd256;
            cfg_reg.mag        <= '0;
            cfg_reg.apos       <= '0;
            cfg_reg.axis       <= '0;
            cfg_reg.strength   <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_index))
                REG_SIZE_X:   cfg_reg.size_x     <= cfg_wdata[11:0];
                REG_SIZE_Y:   cfg_reg.size_y     <= cfg_wdata[11:0];
                REG_MODE:     cfg_reg.mode       <= cfg_wdata[4:0];
                REG_SHADES:   cfg_reg.num_shades <= cfg_wdata[8:0];
                REG_MAG:      cfg_reg.mag        <= cfg_wdata;
                REG_APOS:     cfg_reg.apos       <= cfg_wdata;
                REG_AXIS:     cfg_reg.axis       <= cfg_wdata[47:0];
                REG_STRENGTH: cfg_reg.strength   <= cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    pmot_motion u_motion (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .out_valid (mot_valid),
        .out_ready (mot_ready),
        .out_item  (mot_item)
    );

    pmot_drag u_drag (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (mot_valid),
        .in_ready  (mot_ready),
        .in_item   (mot_item),
        .out_valid (drg_valid),
        .out_ready (drg_ready),
        .out_item  (drg_item)
    );

    pmot_force u_force (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (drg_valid),
        .in_ready  (drg_ready),
        .in_item   (drg_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (frc_item)
    );

    // result word
    assign m_tdata = {1'b0, frc_item.age, frc_item.shade,
                      frc_item.v[2], frc_item.v[1], frc_item.v[0],
                      frc_item.p[2], frc_item.p[1], frc_item.p[0]};
    assign m_tuser = frc_item.dead;

    // a dead particle leaves with shade zero
    a_dead_shade: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[199:192] == 8'd0)
        else $error("dead particle with nonzero shade");

    // input only blocks when every stage is full and the output is stalled
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled with room in the pipeline");

    // nothing leaves straight after reset
    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result word valid after reset");

endmodule

/* src/pmot_motion.sv */
// pmot_motion: aging, Euler position step, edge rule and attractor gain
// depends on pmot_pkg; two register stages
module pmot_motion (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  pmot_pkg::cfg_t             cfg,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [pmot_pkg::IN_W-1:0]  in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output pmot_pkg::item_t            out_item
);
    import pmot_pkg::*;

    localparam int N = 2;

    logic [N-1:0] vld_reg;
    logic [N-1:0] vld_shift;
    logic [N-1:0] adv;

    // field extraction
    s32_t        in_p [3];
    s32_t        in_v [3];
    logic [7:0]  in_shade;
    logic [30:0] in_age;
    logic [30:0] in_life;
    logic [30:0] in_dt;

    logic [31:0]       age_sum;
    logic [31:0]       age_a;
    logic              over;
    logic [5:0]        dec;
    logic signed [9:0] shade_s;
    logic signed [62:0] pd [3];
    logic signed [62:0] qsp;

    // stage 1 registers
    s32_t               p1_reg [3];
    s32_t               v1_reg [3];
    logic signed [62:0] pd1_reg [3];
    logic signed [62:0] qsp1_reg;
    logic [31:0]        drag1_reg;
    logic [30:0]        dt1_reg;
    logic [7:0]         shade1_reg;
    logic [30:0]        age1_reg;
    logic               dead1_reg;

    // stage 2 register
    item_t item_reg;
    item_t item_next;

    logic [11:0] sz [3];

    // stall chain: a stage moves when empty or when the next one moves
    always_comb begin
        adv[N-1] = !vld_reg[N-1] || out_ready;
        for (int k = N - 2; k >= 0; k--) begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
        vld_shift = {vld_reg[N-2:0], in_valid};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= (vld_reg & ~adv) | (vld_shift & adv);
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[N-1];
    assign out_item  = item_reg;

    // aging and the velocity by time step products
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            in_p[i] = in_data[32*i +: 32];
            in_v[i] = in_data[96 + 32*i +: 32];
        end
        in_shade = in_data[231:224];
        in_age   = in_data[262:232];
        in_life  = in_data[293:263];
        in_dt    = in_data[324:294];

        age_sum = {1'b0, in_age} + {1'b0, in_dt};
        over    = age_sum > {1'b0, in_life};
        dec     = 6'((10'(cfg.num_shades) + 10'd15) >> 4);
        shade_s = $signed({2'b00, in_shade}) - (over ? $signed({4'b0000, dec}) : 10'sd0);
        age_a   = over ? (age_sum - {1'b0, in_life}) : age_sum;

        for (int i = 0; i < 3; i++) begin
            pd[i] = in_v[i] * $signed({1'b0, in_dt});
        end
        qsp = $signed(cfg.strength) * $signed({1'b0, in_dt});
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            for (int i = 0; i < 3; i++) begin
                p1_reg[i]  <= in_p[i];
                v1_reg[i]  <= in_v[i];
                pd1_reg[i] <= pd[i];
            end
            qsp1_reg   <= qsp;
            drag1_reg  <= in_data[223:192];
            dt1_reg    <= in_dt;
            shade1_reg <= shade_s[7:0];
            age1_reg   <= age_a[31] ? 31'h7FFFFFFF : age_a[30:0];
            dead1_reg  <= shade_s[9];
        end
    end

    // one axis of the edge rule, returns position over velocity
    function automatic logic [63:0] edge_fix(input logic signed [48:0] pn,
                                             input s32_t v,
                                             input logic [11:0] size,
                                             input logic [1:0] mode);
        logic [11:0]        se;
        logic signed [48:0] lim;
        logic signed [48:0] top;
        logic signed [48:0] pr;
        s32_t               vr;
        logic               hit;
        se  = (size == 12'd0) ? 12'd1 : size;
        lim = $signed(49'(se) << FRAC);
        top = $signed(49'(se - 12'd1) << FRAC);
        pr  = pn;
        vr  = v;
        hit = 1'b0;
        case (edge_mode_t'(mode))
            EDGE_WRAP: begin
                if (pn < 0) begin
                    pr = pn + lim;
                end else if (pn >= lim) begin
                    pr = pn - lim;
                end
            end
            default: begin
                if (pn < 0) begin
                    pr  = '0;
                    hit = 1'b1;
                end else if (pn >= lim) begin
                    pr  = top;
                    hit = 1'b1;
                end
                if (hit && edge_mode_t'(mode) == EDGE_BOUNCE) begin
                    vr = (v == 32'sh80000000) ? 32'sh7FFFFFFF : -v;
                end
            end
        endcase
        return {sat32(64'(pr)), vr};
    endfunction

    // position step and edge rule per axis
    always_comb begin
        logic signed [48:0] pn;
        logic [63:0]        pv;
        sz[0] = cfg.size_x;
        sz[1] = cfg.size_y;
        sz[2] = (cfg.size_x < cfg.size_y) ? cfg.size_x : cfg.size_y;
        item_next = '0;
        for (int i = 0; i < 3; i++) begin
            pn = 49'($signed(p1_reg[i])) + 49'(pd1_reg[i] >>> FRAC);
            pv = edge_fix(pn, v1_reg[i], sz[i], cfg.mode[1:0]);
            item_next.p[i] = dead1_reg ? p1_reg[i] : pv[63:32];
            item_next.v[i] = dead1_reg ? v1_reg[i] : pv[31:0];
        end
        item_next.qs    = sat32(64'(qsp1_reg >>> FRAC));
        item_next.drag  = drag1_reg;
        item_next.dt    = dt1_reg;
        item_next.shade = dead1_reg ? 8'd0 : shade1_reg;
        item_next.age   = age1_reg;
        item_next.dead  = dead1_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            item_reg <= item_next;
        end
    end

endmodule

/* src/pmot_drag.sv */
// pmot_drag: speed squared, drag multiplier and velocity damping
// depends on pmot_pkg; five register stages
module pmot_drag (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  pmot_pkg::item_t in_item,
    output logic            out_valid,
    input  logic            out_ready,
    output pmot_pkg::item_t out_item
);
    import pmot_pkg::*;

    localparam int N = 5;

    logic [N-1:0] vld_reg;
    logic [N-1:0] vld_shift;
    logic [N-1:0] adv;

    item_t it1_reg, it2_reg, it3_reg, it4_reg, it5_reg;
    item_t it5_next;

    logic [62:0]        sq1_reg [3];
    logic [22:0]        sqf2_reg;
    logic [54:0]        mp3_reg;
    logic signed [44:0] vm4_reg [3];

    logic [63:0]        sq_sum;
    logic [63:0]        sq_cap;
    logic [30:0]        m_raw;
    logic [11:0]        mul;

    // stall chain
    always_comb begin
        adv[N-1] = !vld_reg[N-1] || out_ready;
        for (int k = N - 2; k >= 0; k--) begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
        vld_shift = {vld_reg[N-2:0], in_valid};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= (vld_reg & ~adv) | (vld_shift & adv);
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[N-1];
    assign out_item  = it5_reg;

    // squares of the velocity components
    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            it1_reg <= in_item;
            for (int i = 0; i < 3; i++) begin
                sq1_reg[i] <= 63'($signed(in_item.v[i]) * $signed(in_item.v[i]));
            end
        end
    end

    // sum and cap
    always_comb begin
        sq_sum = 64'(sq1_reg[0]) + 64'(sq1_reg[1]) + 64'(sq1_reg[2]);
        sq_cap = (sq_sum > VSQ_CAP) ? VSQ_CAP : sq_sum;
    end

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            it2_reg  <= it1_reg;
            sqf2_reg <= 23'(sq_cap >> FRAC);
        end
    end

    // speed squared times drag
    always_ff @(posedge aclk) begin
        if (adv[2]) begin
            it3_reg <= it2_reg;
            mp3_reg <= 55'(sqf2_reg) * 55'(it2_reg.drag);
        end
    end

    // multiplier cap, then velocity by multiplier
    always_comb begin
        m_raw = mp3_reg[54:24];
        mul   = (m_raw > 31'(MUL_CAP)) ? MUL_CAP : m_raw[11:0];
        if (it3_reg.dead) begin
            mul = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[3]) begin
            it4_reg <= it3_reg;
            for (int i = 0; i < 3; i++) begin
                vm4_reg[i] <= $signed(it3_reg.v[i]) * $signed({1'b0, mul});
            end
        end
    end

    // damped velocity
    always_comb begin
        it5_next = it4_reg;
        for (int i = 0; i < 3; i++) begin
            it5_next.v[i] = 32'(34'($signed(it4_reg.v[i])) - 34'(vm4_reg[i] >>> FRAC));
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[4]) begin
            it5_reg <= it5_next;
        end
    end

endmodule

/* src/pmot_force.sv */
// pmot_force: magnetic force and point or axis attractor on the velocity
// depends on pmot_pkg; seven register stages, the last is the output register
module pmot_force (
    input  logic            aclk,
    input  logic            aresetn,
    input  pmot_pkg::cfg_t  cfg,
    input  logic            in_valid,
    output logic            in_ready,
    input  pmot_pkg::item_t in_item,
    output logic            out_valid,
    input  logic            out_ready,
    output pmot_pkg::item_t out_item
);
    import pmot_pkg::*;

    localparam int N = 7;

    logic [N-1:0] vld_reg;
    logic [N-1:0] vld_shift;
    logic [N-1:0] adv;

    item_t it1_reg, it2_reg, it3_reg, it4_reg, it5_reg, it6_reg, it7_reg;
    item_t it4_next, it7_next;

    logic signed [20:0] bf [3];
    logic signed [15:0] ax [3];
    logic signed [27:0] ap [3];

    logic signed [52:0] mb1_reg [6];
    logic signed [33:0] d1_reg [3];
    logic signed [33:0] d2_reg [3];
    logic signed [33:0] d3_reg [3];
    logic signed [33:0] d4_reg [3];
    s32_t               am2_reg [3];
    logic signed [49:0] dp2_reg [3];
    logic signed [62:0] amd3_reg [3];
    logic signed [37:0] q3_reg;
    logic signed [53:0] qa4_reg [3];
    s32_t               aa5_reg [3];
    logic signed [63:0] aq6_reg [3];

    logic signed [51:0] dot;
    logic               att_en7;

    // stall chain
    always_comb begin
        adv[N-1] = !vld_reg[N-1] || out_ready;
        for (int k = N - 2; k >= 0; k--) begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
        vld_shift = {vld_reg[N-2:0], in_valid};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= (vld_reg & ~adv) | (vld_shift & adv);
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[N-1];
    assign out_item  = it7_reg;

    // unpack field, axis and attractor point
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            bf[i] = $signed(cfg.mag[21*i +: 21]);
            ax[i] = $signed(cfg.axis[16*i +: 16]);
            ap[i] = 28'($signed(cfg.apos[21*i +: 21])) <<< ATT_SHIFT;
        end
    end

    // cross product terms and offset from the attractor
    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            it1_reg    <= in_item;
            mb1_reg[0] <= $signed(in_item.v[1]) * bf[2];
            mb1_reg[1] <= $signed(in_item.v[2]) * bf[1];
            mb1_reg[2] <= $signed(in_item.v[2]) * bf[0];
            mb1_reg[3] <= $signed(in_item.v[0]) * bf[2];
            mb1_reg[4] <= $signed(in_item.v[0]) * bf[1];
            mb1_reg[5] <= $signed(in_item.v[1]) * bf[0];
            for (int i = 0; i < 3; i++) begin
                d1_reg[i] <= 34'($signed(in_item.p[i])) - 34'(ap[i]);
            end
        end
    end

    // cross product, axis projection terms
    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            it2_reg <= it1_reg;
            for (int i = 0; i < 3; i++) begin
                am2_reg[i] <= sat32(64'((54'(mb1_reg[2*i]) - 54'(mb1_reg[2*i+1])) >>> 12));
                dp2_reg[i] <= ax[i] * d1_reg[i];
                d2_reg[i]  <= d1_reg[i];
            end
        end
    end

    // magnetic term by time step, projection length
    always_comb begin
        dot = 52'(dp2_reg[0]) + 52'(dp2_reg[1]) + 52'(dp2_reg[2]);
    end

    always_ff @(posedge aclk) begin
        if (adv[2]) begin
            it3_reg <= it2_reg;
            q3_reg  <= 38'(dot >>> 14);
            for (int i = 0; i < 3; i++) begin
                amd3_reg[i] <= am2_reg[i] * $signed({1'b0, it2_reg.dt});
                d3_reg[i]   <= d2_reg[i];
            end
        end
    end

    // magnetic update, projection back onto the axis
    always_comb begin
        it4_next = it3_reg;
        for (int i = 0; i < 3; i++) begin
            if (cfg.mode[2] && !it3_reg.dead) begin
                it4_next.v[i] = sat32(64'($signed(it3_reg.v[i])) + 64'(amd3_reg[i] >>> FRAC));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[3]) begin
            it4_reg <= it4_next;
            for (int i = 0; i < 3; i++) begin
                qa4_reg[i] <= q3_reg * ax[i];
                d4_reg[i]  <= d3_reg[i];
            end
        end
    end

    // pull vector, toward the point or toward the axis
    always_ff @(posedge aclk) begin
        if (adv[4]) begin
            it5_reg <= it4_reg;
            for (int i = 0; i < 3; i++) begin
                if (cfg.mode[4]) begin
                    aa5_reg[i] <= sat32(64'(41'(qa4_reg[i] >>> 14) - 41'(d4_reg[i])));
                end else begin
                    aa5_reg[i] <= sat32(-64'(d4_reg[i]));
                end
            end
        end
    end

    // pull by gain
    always_ff @(posedge aclk) begin
        if (adv[5]) begin
            it6_reg <= it5_reg;
            for (int i = 0; i < 3; i++) begin
                aq6_reg[i] <= aa5_reg[i] * it5_reg.qs;
            end
        end
    end

    // attractor update into the output register
    always_comb begin
        att_en7  = cfg.mode[3] && !it6_reg.dead;
        it7_next = it6_reg;
        for (int i = 0; i < 3; i++) begin
            if (att_en7) begin
                it7_next.v[i] = sat32(64'($signed(it6_reg.v[i])) + 64'(aq6_reg[i] >>> FRAC));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[6]) begin
            it7_reg <= it7_next;
        end
    end

endmodule
